>>> rtl/core/boruvka_min_spanning_tree_unit_defines.svh
// Assertion macros shared by the minimum spanning tree unit.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef BORUVKA_MIN_SPANNING_TREE_UNIT_DEFINES_SVH
`define BORUVKA_MIN_SPANNING_TREE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BMST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BMST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BMST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/bmst_pkg.sv
// Shared types and constants of the minimum spanning tree unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package bmst_pkg;

    localparam int VW  = 6;   // vertex index width
    localparam int WW  = 32;  // edge weight width
    localparam int NW  = 7;   // vertex count width
    localparam int SZW = 7;   // component size width

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROUND,
        ST_SC_EDGE,
        ST_SC_LBL,
        ST_SC_CH,
        ST_SC_UA,
        ST_SC_UB,
        ST_MG_CHK,
        ST_MG_EDGE,
        ST_MG_LBL,
        ST_MG_SIZE,
        ST_MG_MERGE,
        ST_RL_RD,
        ST_RL_WR,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic vcnt_clr;
        logic init_step;
        logic init_done;
        logic round_start;
        logic edge_rd_scan;
        logic edge_rd_merge;
        logic lbl_rd;
        logic ch_rd_scan;
        logic ch_rd_merge;
        logic upd_a;
        logic upd_b;
        logic eidx_inc;
        logic vcnt_inc;
        logic size_rd;
        logic merge;
        logic rl_rd;
        logic rl_wr;
        logic push_final;
        logic push_empty;
        logic run_end;
    } cmd_t;

    typedef struct packed {
        logic eidx_end;
        logic vcnt_end;
        logic edge_ok;
        logic same_root;
        logic ch_valid;
        logic more_rounds;
        logic pend_valid;
        logic out_free;
        logic rl_end;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/bmst_ctrl.sv
// Sequencer of the minimum spanning tree unit: loading, rounds, merges, relabeling.
// Depends on bmst_pkg for the state, command and status types.
`default_nettype none
module bmst_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tlast,
    input  wire bmst_pkg::sts_t sts,
    output bmst_pkg::cmd_t     cmd
);
    import bmst_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && s_tlast)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (sts.vcnt_end)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = sts.more_rounds ? ST_SC_EDGE : ST_FLUSH;
            end
            ST_SC_EDGE:
            begin
                state_next = sts.eidx_end ? ST_MG_CHK : ST_SC_LBL;
            end
            ST_SC_LBL:
            begin
                state_next = sts.edge_ok ? ST_SC_CH : ST_SC_EDGE;
            end
            ST_SC_CH:
            begin
                state_next = sts.same_root ? ST_SC_EDGE : ST_SC_UA;
            end
            ST_SC_UA:
            begin
                state_next = ST_SC_UB;
            end
            ST_SC_UB:
            begin
                state_next = ST_SC_EDGE;
            end
            ST_MG_CHK:
            begin
                if (sts.vcnt_end)
                begin
                    state_next = ST_ROUND;
                end
                else if (sts.ch_valid)
                begin
                    state_next = ST_MG_EDGE;
                end
            end
            ST_MG_EDGE:
            begin
                state_next = ST_MG_LBL;
            end
            ST_MG_LBL:
            begin
                state_next = ST_MG_SIZE;
            end
            ST_MG_SIZE:
            begin
                state_next = sts.same_root ? ST_MG_CHK : ST_MG_MERGE;
            end
            ST_MG_MERGE:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    state_next = ST_RL_RD;
                end
            end
            ST_RL_RD:
            begin
                state_next = sts.rl_end ? ST_MG_CHK : ST_RL_WR;
            end
            ST_RL_WR:
            begin
                state_next = ST_RL_RD;
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready     = 1'b1;
                cmd.load     = accept;
                cmd.vcnt_clr = accept && s_tlast;
            end
            ST_INIT:
            begin
                cmd.init_step = !sts.vcnt_end;
                cmd.init_done = sts.vcnt_end;
            end
            ST_ROUND:
            begin
                cmd.round_start = sts.more_rounds;
            end
            ST_SC_EDGE:
            begin
                cmd.edge_rd_scan = !sts.eidx_end;
                cmd.vcnt_clr     = sts.eidx_end;
            end
            ST_SC_LBL:
            begin
                cmd.lbl_rd   = sts.edge_ok;
                cmd.eidx_inc = !sts.edge_ok;
            end
            ST_SC_CH:
            begin
                cmd.ch_rd_scan = !sts.same_root;
                cmd.eidx_inc   = sts.same_root;
            end
            ST_SC_UA:
            begin
                cmd.upd_a = 1'b1;
            end
            ST_SC_UB:
            begin
                cmd.upd_b    = 1'b1;
                cmd.eidx_inc = 1'b1;
            end
            ST_MG_CHK:
            begin
                cmd.ch_rd_merge = !sts.vcnt_end && sts.ch_valid;
                cmd.vcnt_inc    = !sts.vcnt_end && !sts.ch_valid;
            end
            ST_MG_EDGE:
            begin
                cmd.edge_rd_merge = 1'b1;
            end
            ST_MG_LBL:
            begin
                cmd.lbl_rd = 1'b1;
            end
            ST_MG_SIZE:
            begin
                cmd.size_rd  = !sts.same_root;
                cmd.vcnt_inc = sts.same_root;
            end
            ST_MG_MERGE:
            begin
                cmd.merge = !sts.pend_valid || sts.out_free;
            end
            ST_RL_RD:
            begin
                cmd.rl_rd    = !sts.rl_end;
                cmd.vcnt_inc = sts.rl_end;
            end
            ST_RL_WR:
            begin
                cmd.rl_wr = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.push_final = sts.out_free && sts.pend_valid;
                cmd.push_empty = sts.out_free && !sts.pend_valid;
                cmd.run_end    = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/bmst_dpath.sv
// Datapath of the minimum spanning tree unit: edge store, component labels,
// sizes, cheapest-edge table and the output register. Depends on bmst_pkg.
`default_nettype none
`include "boruvka_min_spanning_tree_unit_defines.svh"
module bmst_dpath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bmst_pkg::cmd_t             cmd,
    output bmst_pkg::sts_t                  sts,
    input  wire logic                       cfg_valid,
    input  wire logic [bmst_pkg::NW-1:0]    cfg_data,
    input  wire logic [bmst_pkg::VW-1:0]    vertex_a,
    input  wire logic [bmst_pkg::VW-1:0]    vertex_b,
    input  wire logic [bmst_pkg::WW-1:0]    weight,
    input  wire logic                       m_tready,
    output logic                            m_tvalid,
    output logic [bmst_pkg::VW-1:0]         tree_u,
    output logic [bmst_pkg::VW-1:0]         tree_v,
    output logic                            final_res,
    output logic                            empty_forest,
    output logic                            edges_dropped
);
    import bmst_pkg::*;

    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EDW = 2 * VW + WW;
    localparam int CHW = WW + EW;

    logic [EDW-1:0] edge_mem [MAX_EDGES];
    logic [VW-1:0]  lbl_mem  [MAX_VERTICES];
    logic [SZW-1:0] size_mem [MAX_VERTICES];
    logic [CHW-1:0] ch_mem   [MAX_VERTICES];

    logic [NW-1:0]           vcount_reg;
    logic [NW-1:0]           n_act;
    logic [ECW-1:0]          etotal_reg;
    logic                    dropped_reg;
    logic [ECW-1:0]          eidx_reg;
    logic [NW-1:0]           vcnt_reg;
    logic [NW-1:0]           rcnt_reg;
    logic [NW-1:0]           comps_reg;
    logic                    merged_reg;
    logic [MAX_VERTICES-1:0] chv_reg;

    logic [VW-1:0]           e_from_reg;
    logic [VW-1:0]           e_to_reg;
    logic [WW-1:0]           e_cost_reg;
    logic [VW-1:0]           lbl_a_reg;
    logic [VW-1:0]           lbl_b_reg;
    logic [CHW-1:0]          ch_a_reg;
    logic [CHW-1:0]          ch_b_reg;
    logic [SZW-1:0]          sz_a_reg;
    logic [SZW-1:0]          sz_b_reg;
    logic [VW-1:0]           rl_old_reg;
    logic [VW-1:0]           rl_new_reg;
    logic                    pend_v_reg;
    logic [VW-1:0]           pend_u_reg;
    logic [VW-1:0]           pend_w_reg;

    logic                    out_v_reg;
    logic [VW-1:0]           out_u_reg;
    logic [VW-1:0]           out_w_reg;
    logic                    out_fin_reg;
    logic                    out_emp_reg;
    logic                    out_drop_reg;

    logic                    in_ok;
    logic                    out_free;
    logic                    push_pend;
    logic                    a_wins;
    logic                    b_wins;
    logic                    swap;
    logic [VW-1:0]           root_sel;
    logic [VW-1:0]           child_sel;
    logic [EW-1:0]           edge_addr;
    logic [VW-1:0]           ch_addr_a;
    logic [VW-1:0]           lbl_addr_a;

    // Vertex count clamped to the supported range.
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_act = NW'(1);
        end
        else if (vcount_reg > NW'(MAX_VERTICES))
        begin
            n_act = NW'(MAX_VERTICES);
        end
        else
        begin
            n_act = vcount_reg;
        end
    end

    assign in_ok = ({1'b0, vertex_a} < n_act) && ({1'b0, vertex_b} < n_act)
                   && (etotal_reg < ECW'(MAX_EDGES));
    assign out_free  = !out_v_reg || m_tready;
    assign push_pend = cmd.merge && pend_v_reg;

    assign a_wins = !chv_reg[lbl_a_reg] ||
                    ($signed(e_cost_reg) < $signed(ch_a_reg[CHW-1:EW]));
    assign b_wins = !chv_reg[lbl_b_reg] ||
                    ($signed(e_cost_reg) < $signed(ch_b_reg[CHW-1:EW]));

    // On equal sizes the root of the edge's first endpoint stays root.
    assign swap      = sz_a_reg < sz_b_reg;
    assign root_sel  = swap ? lbl_b_reg : lbl_a_reg;
    assign child_sel = swap ? lbl_a_reg : lbl_b_reg;

    assign edge_addr  = cmd.edge_rd_merge ? ch_a_reg[EW-1:0] : eidx_reg[EW-1:0];
    assign ch_addr_a  = cmd.ch_rd_merge ? vcnt_reg[VW-1:0] : lbl_a_reg;
    assign lbl_addr_a = cmd.rl_rd ? rcnt_reg[VW-1:0] : e_from_reg;

    always_comb
    begin
        sts.eidx_end    = eidx_reg == etotal_reg;
        sts.vcnt_end    = vcnt_reg == n_act;
        sts.edge_ok     = ({1'b0, e_from_reg} < n_act) && ({1'b0, e_to_reg} < n_act);
        sts.same_root   = lbl_a_reg == lbl_b_reg;
        sts.ch_valid    = chv_reg[vcnt_reg[VW-1:0]];
        sts.more_rounds = (comps_reg > NW'(1)) && merged_reg;
        sts.pend_valid  = pend_v_reg;
        sts.out_free    = out_free;
        sts.rl_end      = rcnt_reg == n_act;
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_ok)
        begin
            edge_mem[etotal_reg[EW-1:0]] <= {weight, vertex_b, vertex_a};
        end
        if (cmd.edge_rd_scan || cmd.edge_rd_merge)
        begin
            {e_cost_reg, e_to_reg, e_from_reg} <= edge_mem[edge_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_step)
        begin
            lbl_mem[vcnt_reg[VW-1:0]] <= vcnt_reg[VW-1:0];
        end
        else if (cmd.rl_wr && (lbl_a_reg == rl_old_reg))
        begin
            lbl_mem[rcnt_reg[VW-1:0]] <= rl_new_reg;
        end
        if (cmd.lbl_rd || cmd.rl_rd)
        begin
            lbl_a_reg <= lbl_mem[lbl_addr_a];
        end
        if (cmd.lbl_rd)
        begin
            lbl_b_reg <= lbl_mem[e_to_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_step)
        begin
            size_mem[vcnt_reg[VW-1:0]] <= SZW'(1);
        end
        else if (cmd.merge)
        begin
            size_mem[root_sel] <= sz_a_reg + sz_b_reg;
        end
        if (cmd.size_rd)
        begin
            sz_a_reg <= size_mem[lbl_a_reg];
            sz_b_reg <= size_mem[lbl_b_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_a && a_wins)
        begin
            ch_mem[lbl_a_reg] <= {e_cost_reg, eidx_reg[EW-1:0]};
        end
        else if (cmd.upd_b && b_wins)
        begin
            ch_mem[lbl_b_reg] <= {e_cost_reg, eidx_reg[EW-1:0]};
        end
        if (cmd.ch_rd_scan || cmd.ch_rd_merge)
        begin
            ch_a_reg <= ch_mem[ch_addr_a];
        end
        if (cmd.ch_rd_scan)
        begin
            ch_b_reg <= ch_mem[lbl_b_reg];
        end
    end

    // Merge bookkeeping and the pending tree edge.
    always_ff @(posedge clk)
    begin
        if (cmd.merge)
        begin
            rl_old_reg <= child_sel;
            rl_new_reg <= root_sel;
            pend_u_reg <= e_from_reg;
            pend_w_reg <= e_to_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg   <= NW'(64);
            etotal_reg   <= '0;
            dropped_reg  <= 1'b0;
            eidx_reg     <= '0;
            vcnt_reg     <= '0;
            rcnt_reg     <= '0;
            comps_reg    <= NW'(MAX_VERTICES);
            merged_reg   <= 1'b0;
            chv_reg      <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            out_u_reg    <= '0;
            out_w_reg    <= '0;
            out_fin_reg  <= 1'b0;
            out_emp_reg  <= 1'b0;
            out_drop_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vcount_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                if (in_ok)
                begin
                    etotal_reg <= etotal_reg + ECW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.run_end)
            begin
                etotal_reg  <= '0;
                dropped_reg <= 1'b0;
            end

            if (cmd.vcnt_clr)
            begin
                vcnt_reg <= '0;
            end
            else if (cmd.init_step || cmd.vcnt_inc)
            begin
                vcnt_reg <= vcnt_reg + NW'(1);
            end

            if (cmd.round_start)
            begin
                eidx_reg <= '0;
            end
            else if (cmd.eidx_inc)
            begin
                eidx_reg <= eidx_reg + ECW'(1);
            end

            if (cmd.init_done)
            begin
                comps_reg  <= n_act;
                merged_reg <= 1'b1;
            end
            else if (cmd.round_start)
            begin
                merged_reg <= 1'b0;
            end
            else if (cmd.merge)
            begin
                comps_reg  <= comps_reg - NW'(1);
                merged_reg <= 1'b1;
            end

            if (cmd.round_start)
            begin
                chv_reg <= '0;
            end
            else if (cmd.upd_a && a_wins)
            begin
                chv_reg[lbl_a_reg] <= 1'b1;
            end
            else if (cmd.upd_b && b_wins)
            begin
                chv_reg[lbl_b_reg] <= 1'b1;
            end

            if (cmd.merge)
            begin
                rcnt_reg <= '0;
            end
            else if (cmd.rl_wr)
            begin
                rcnt_reg <= rcnt_reg + NW'(1);
            end

            if (cmd.merge)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (cmd.run_end)
            begin
                pend_v_reg <= 1'b0;
            end

            if (push_pend || cmd.push_final || cmd.push_empty)
            begin
                out_v_reg    <= 1'b1;
                out_u_reg    <= cmd.push_empty ? '0 : pend_u_reg;
                out_w_reg    <= cmd.push_empty ? '0 : pend_w_reg;
                out_fin_reg  <= cmd.push_final || cmd.push_empty;
                out_emp_reg  <= cmd.push_empty;
                out_drop_reg <= dropped_reg;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = out_v_reg;
    assign tree_u        = out_u_reg;
    assign tree_v        = out_w_reg;
    assign final_res     = out_fin_reg;
    assign empty_forest  = out_emp_reg;
    assign edges_dropped = out_drop_reg;

    `BMST_ASSERT_IMP(a_etotal_cap, clk, rst_n, 1'b1, etotal_reg <= ECW'(MAX_EDGES), "edge count above capacity")
    `BMST_ASSERT_IMP(a_merge_distinct, clk, rst_n, cmd.merge, lbl_a_reg != lbl_b_reg, "merge of one component with itself")
    `BMST_ASSERT_IMP(a_merge_comps, clk, rst_n, cmd.merge, comps_reg > NW'(1), "merge with a single component left")
    `BMST_ASSERT_IMP(a_push_free, clk, rst_n, push_pend || cmd.push_final || cmd.push_empty, out_free, "result pushed into a full output register")

endmodule
`default_nettype wire

>>> rtl/core/boruvka_min_spanning_tree_unit.sv
// Edges load at one item per cycle while the unit is in its load phase.
// After the item marked tlast, compute runs a label setup and then rounds; each round scans every
// stored edge, then the cheapest edge of each component, and each merge adds a relabel sweep.
// Results leave through one output register; a stalled output holds the next merge.
// rst_n is asynchronous and clears all control state; the vertex count returns to 64.
// Top level of the minimum spanning tree unit; uses bmst_pkg, bmst_ctrl, bmst_dpath.
`default_nettype none
module boruvka_min_spanning_tree_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,    // vertex_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,     // vertex_a[5:0], vertex_b[11:6], weight[43:12]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,     // tree_u[5:0], tree_v[11:6]
    output logic             m_tlast,
    output logic [1:0]       m_tuser      // empty_forest[0], edges_dropped[1]
);
    import bmst_pkg::*;

    cmd_t          cmd;
    sts_t          sts;
    logic [VW-1:0] tree_u;
    logic [VW-1:0] tree_v;
    logic          empty_forest;
    logic          edges_dropped;

    assign cfg_ready = 1'b1;

    bmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmst_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .vertex_a      (s_tdata[5:0]),
        .vertex_b      (s_tdata[11:6]),
        .weight        (s_tdata[43:12]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .tree_u        (tree_u),
        .tree_v        (tree_v),
        .final_res     (m_tlast),
        .empty_forest  (empty_forest),
        .edges_dropped (edges_dropped)
    );

    assign m_tdata = {4'b0000, tree_v, tree_u};
    assign m_tuser = {edges_dropped, empty_forest};

endmodule
`default_nettype wire
